// ===== hdl/dual_motor_ramp_drive_unit_assert.svh =====
// Assertion macros used by the checker of the drive unit.
`ifndef DUAL_MOTOR_RAMP_DRIVE_UNIT_ASSERT_SVH
`define DUAL_MOTOR_RAMP_DRIVE_UNIT_ASSERT_SVH

// Immediate-cycle property, checked at every clock edge outside reset.
`define DMRD_ASSERT_NOW(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("drive unit check failed");

// Implication property, checked at every clock edge outside reset.
`define DMRD_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("drive unit check failed");

`endif

// ===== hdl/dmrd_pkg.sv =====
package dmrd_pkg;

  localparam int unsigned DriveMax = 255;

  localparam logic [15:0] RampStepReset  = 16'd5;
  localparam logic [15:0] RampPeriodReset = 16'd20;
  localparam logic [15:0] TimeoutReset   = 16'd200;
  localparam logic [15:0] MinPwmReset    = 16'd10;

  // Reciprocal of 254 scaled by 2^24, rounded up; exact for 16-bit dividends.
  localparam logic [16:0] RecipK     = 17'd66053;
  localparam int unsigned RecipShift = 24;

  typedef enum logic [1:0] {
    REG_RAMP_STEP   = 2'd0,
    REG_RAMP_PERIOD = 2'd1,
    REG_TIMEOUT     = 2'd2,
    REG_MIN_PWM     = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    DIR_BRAKE   = 2'd0,
    DIR_FORWARD = 2'd1,
    DIR_REVERSE = 2'd2
  } dir_t;

  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_SET  = 1'b1
  } cmd_t;

  typedef struct packed {
    logic set;
    logic clear_goal;
    logic ramp;
  } ctl_t;

  function automatic logic signed [8:0] clamp_target(input logic signed [8:0] t);
    logic signed [8:0] r;
    r = t;
    if (t == -9'sd256) begin
      r = -9'sd255;
    end
    return r;
  endfunction

endpackage

// ===== hdl/dual_motor_ramp_drive_unit.sv =====
// A result passes through the s1 and s2 stage registers and then the output register.
// Throughput: one beat per cycle unless the output stalls; the ramp state updates in the
// accepting cycle and the duty remap is a two-stage multiply pipeline behind it.
// A stalled output register holds the whole pipeline and input ready drops with it.
// Reset is synchronous: targets, drive values, both ms counters and the pipeline valid
// flags clear, and the configuration registers return to their default values.
module dual_motor_ramp_drive_unit import dmrd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // left_target[8:0], right_target[17:9], zero[23:18]
  input  logic        s_axis_tuser,  // command[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // left_duty[7:0], left_direction[9:8],
                                     // right_duty[17:10], right_direction[19:18], zero[23:20]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [7:0]  step_size;
  logic [15:0] ramp_period_ms;
  logic [15:0] command_timeout_ms;
  logic [7:0]  min_pwm;

  logic adv;
  logic acc;
  logic v1;
  logic v2;
  ctl_t ctl;

  logic [7:0] left_duty;
  logic [7:0] right_duty;
  dir_t       left_dir;
  dir_t       right_dir;

  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign acc           = s_axis_tvalid && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_size          <= RampStepReset[7:0];
      ramp_period_ms     <= RampPeriodReset;
      command_timeout_ms <= TimeoutReset;
      min_pwm            <= MinPwmReset[7:0];
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_RAMP_STEP:   step_size          <= cfg_data[7:0];
        REG_RAMP_PERIOD: ramp_period_ms     <= cfg_data;
        REG_TIMEOUT:     command_timeout_ms <= cfg_data;
        REG_MIN_PWM:     min_pwm            <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  dmrd_timer u_timer (
    .clk                (clk),
    .rst                (rst),
    .acc                (acc),
    .command            (s_axis_tuser),
    .ramp_period_ms     (ramp_period_ms),
    .command_timeout_ms (command_timeout_ms),
    .ctl                (ctl)
  );

  dmrd_lane u_left (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .acc       (acc),
    .ctl       (ctl),
    .target    (s_axis_tdata[8:0]),
    .step_size (step_size),
    .min_pwm   (min_pwm),
    .duty      (left_duty),
    .dir       (left_dir)
  );

  dmrd_lane u_right (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .acc       (acc),
    .ctl       (ctl),
    .target    (s_axis_tdata[17:9]),
    .step_size (step_size),
    .min_pwm   (min_pwm),
    .duty      (right_duty),
    .dir       (right_dir)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1            <= 1'b0;
      v2            <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      v1            <= acc;
      v2            <= v1;
      m_axis_tvalid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v2) begin
      m_axis_tdata <= {4'b0000, right_dir, right_duty, left_dir, left_duty};
    end
  end

endmodule

// ===== hdl/dmrd_timer.sv =====
module dmrd_timer import dmrd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        acc,
  input  logic        command,
  input  logic [15:0] ramp_period_ms,
  input  logic [15:0] command_timeout_ms,
  output ctl_t        ctl
);

  logic [15:0] since_command;
  logic [15:0] since_ramp;
  logic [15:0] since_command_next;
  logic [15:0] since_ramp_next;
  logic        is_set;

  assign is_set = (cmd_t'(command) == CMD_SET);

  always_comb begin
    since_command_next = (since_command == 16'hFFFF) ? since_command : since_command + 16'd1;
    since_ramp_next    = (since_ramp == 16'hFFFF) ? since_ramp : since_ramp + 16'd1;
    ctl.set        = is_set;
    ctl.clear_goal = !is_set && (since_command_next > command_timeout_ms);
    ctl.ramp       = !is_set && (since_ramp_next >= ramp_period_ms);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      since_command <= '0;
      since_ramp    <= '0;
    end else if (acc) begin
      if (is_set) begin
        since_command <= '0;
      end else begin
        since_command <= since_command_next;
        since_ramp    <= ctl.ramp ? 16'd0 : since_ramp_next;
      end
    end
  end

endmodule

// ===== hdl/dmrd_lane.sv =====
module dmrd_lane import dmrd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              acc,
  input  ctl_t              ctl,
  input  logic signed [8:0] target,
  input  logic [7:0]        step_size,
  input  logic [7:0]        min_pwm,
  output logic [7:0]        duty,
  output dir_t              dir
);

  logic signed [8:0]  goal;
  logic signed [8:0]  current;
  logic signed [8:0]  goal_eff;
  logic signed [8:0]  current_next;
  logic signed [10:0] cur_w;
  logic signed [10:0] goal_w;
  logic signed [10:0] step_w;
  logic signed [10:0] moved;
  logic [8:0]         mag;
  logic [7:0]         magm1_next;
  dir_t               dir_next;

  logic [7:0]  s1_magm1;
  dir_t        s1_dir;
  logic [15:0] s2_prod;
  dir_t        s2_dir;
  logic [7:0]  scale;
  logic [32:0] quot_w;

  always_comb begin
    goal_eff = ctl.clear_goal ? 9'sd0 : goal;
    cur_w    = {{2{current[8]}}, current};
    goal_w   = {{2{goal_eff[8]}}, goal_eff};
    step_w   = {3'b000, step_size};
    moved    = cur_w;
    current_next = current;
    if (ctl.ramp) begin
      if (goal_w < cur_w) begin
        moved = cur_w - step_w;
        current_next = (moved < goal_w) ? goal_eff : moved[8:0];
      end else if (goal_w > cur_w) begin
        moved = cur_w + step_w;
        current_next = (moved > goal_w) ? goal_eff : moved[8:0];
      end
    end
    mag = current_next[8] ? 9'(-current_next) : current_next;
    if (current_next == 9'sd0) begin
      dir_next   = DIR_BRAKE;
      magm1_next = '0;
    end else begin
      dir_next   = current_next[8] ? DIR_REVERSE : DIR_FORWARD;
      magm1_next = mag[7:0] - 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      goal    <= '0;
      current <= '0;
    end else if (acc) begin
      if (ctl.set) begin
        goal <= clamp_target(target);
      end else begin
        goal    <= goal_eff;
        current <= current_next;
      end
    end
  end

  assign scale = 8'(DriveMax) - min_pwm;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_magm1 <= magm1_next;
      s1_dir   <= dir_next;
      s2_prod  <= 16'(s1_magm1 * scale);
      s2_dir   <= s1_dir;
    end
  end

  always_comb begin
    quot_w = 33'(s2_prod * RecipK);
    duty   = (s2_dir == DIR_BRAKE) ? 8'd0 : (quot_w[RecipShift +: 8] + min_pwm);
    dir    = s2_dir;
  end

endmodule

// ===== hdl/dmrd_checker.sv =====
`include "dual_motor_ramp_drive_unit_assert.svh"

module dmrd_checker import dmrd_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  logic [7:0] l_duty;
  logic [7:0] r_duty;
  logic [1:0] l_dir;
  logic [1:0] r_dir;
  logic       out_stall;
  logic       dirs_legal;
  logic       brakes_idle;

  assign l_duty      = m_axis_tdata[7:0];
  assign l_dir       = m_axis_tdata[9:8];
  assign r_duty      = m_axis_tdata[17:10];
  assign r_dir       = m_axis_tdata[19:18];
  assign out_stall   = m_axis_tvalid && !m_axis_tready;
  assign dirs_legal  = (l_dir <= DIR_REVERSE) && (r_dir <= DIR_REVERSE);
  assign brakes_idle = (l_dir != DIR_BRAKE || l_duty == 8'd0) &&
                       (r_dir != DIR_BRAKE || r_duty == 8'd0);

  `DMRD_ASSERT_IMPL(a_out_hold, clk, rst, out_stall, m_axis_tvalid && $stable(m_axis_tdata))
  `DMRD_ASSERT_NOW(a_dir_legal, clk, rst, !m_axis_tvalid || dirs_legal)
  `DMRD_ASSERT_NOW(a_brake_zero, clk, rst, !m_axis_tvalid || brakes_idle)
  `DMRD_ASSERT_NOW(a_pad_zero, clk, rst, !m_axis_tvalid || m_axis_tdata[23:20] == 4'd0)

endmodule

bind dual_motor_ramp_drive_unit dmrd_checker u_dmrd_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
